/* hw/rtl/cbf_pkg.sv */
package cbf_pkg;

  localparam int unsigned DATA_BYTES_DEF = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // one finished data word, held until all of its results are taken
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } stage_t;

  // crc-16 over one byte, msb first, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        top;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      top = |(c & CRC_TOP);
      c = {c[14:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/cbf_crc_core.sv */
module cbf_crc_core #(
  parameter int unsigned DATA_BYTES = cbf_pkg::DATA_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            pop,
  output cbf_pkg::stage_t stage
);
  import cbf_pkg::*;

  localparam int unsigned CNT_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_BYTES - 1);

  logic [15:0]      crc_reg;
  logic [15:0]      crc_next;
  logic [CNT_W-1:0] byte_count;
  logic             last;
  logic             accept;

  assign in_ready = !stage.valid || pop;
  assign accept   = in_valid && in_ready;
  assign crc_next = crc_feed(crc_reg, data_byte);
  assign last     = (byte_count == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg     <= CRC_INIT;
      byte_count  <= '0;
      stage.valid <= 1'b0;
    end else if (accept) begin
      crc_reg     <= last ? CRC_INIT : crc_next;
      byte_count  <= last ? '0 : byte_count + 1'b1;
      stage.valid <= 1'b1;
    end else if (pop) begin
      stage.valid <= 1'b0;
    end
    // payload, no reset
    if (accept) begin
      stage.data <= data_byte;
      stage.last <= last;
      stage.crc  <= crc_next;
    end
  end

endmodule

/* hw/rtl/cbf_emit.sv */
module cbf_emit (
  input  logic            clk,
  input  logic            rst,
  input  cbf_pkg::stage_t stage,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            is_crc,
  output logic            packet_end
);
  import cbf_pkg::*;

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       take;

  assign out_valid = stage.valid;
  assign take      = out_valid && out_ready;

  always_comb begin
    out_byte   = stage.data;
    is_crc     = 1'b0;
    packet_end = 1'b0;
    phase_next = phase;
    pop        = 1'b0;
    unique case (phase)
      PH_HI: begin
        out_byte = stage.crc[15:8];
        is_crc   = 1'b1;
        if (take) begin
          phase_next = PH_LO;
        end
      end
      PH_LO: begin
        out_byte   = stage.crc[7:0];
        is_crc     = 1'b1;
        packet_end = 1'b1;
        if (take) begin
          phase_next = PH_DATA;
          pop        = 1'b1;
        end
      end
      default: begin
        if (take) begin
          if (stage.last) begin
            phase_next = PH_HI;
          end else begin
            pop = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DATA;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

/* hw/rtl/crc16_block_framer_unit.sv */
// channel | signals                        | direction | word
// input   | in_valid, in_ready, data_byte  | in        | one data byte
// output  | out_valid, out_ready, out_byte,| out       | data byte or crc byte,
//         | is_crc, packet_end             |           | packet_end on crc low byte
//
// one data byte per cycle while in_ready is high; its echo shows the next cycle
// the last byte of each group of DATA_BYTES holds the single stage register
// for three output words, so in_ready stays low until the crc low byte is taken
// in_ready follows out_ready through the stage register's free/pop logic
// rst is synchronous, active high; crc returns to 0xffff and the count to zero
// output stalls hold out_byte, is_crc and packet_end steady
module crc16_block_framer_unit #(
  parameter int unsigned DATA_BYTES = cbf_pkg::DATA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_crc,
  output logic       packet_end
);
  import cbf_pkg::*;

  // finished word, with its post-byte crc and group-end flag
  stage_t stage;
  // stage register released by the output side
  logic   pop;

  // crc and byte count, updated on each accepted byte
  cbf_crc_core #(
    .DATA_BYTES(DATA_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_byte(data_byte),
    .pop      (pop),
    .stage    (stage)
  );

  // walks data, crc high, crc low for the closing byte of a group
  cbf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_crc    (is_crc),
    .packet_end(packet_end)
  );

endmodule

/* hw/rtl/cbf_checker.sv */
module cbf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_crc,
  input logic       packet_end
);

  // end of packet is always a crc byte
  a_end_is_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> is_crc)
    else $error("packet_end on a non-crc word");

  // crc high byte taken, low byte follows at once
  a_lo_follows_hi: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_crc && !packet_end |=> out_valid && is_crc && packet_end)
    else $error("crc low byte missing after high byte");

  // no new byte taken while the crc high byte is showing
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_crc && !packet_end |-> !in_ready)
    else $error("input accepted during crc emission");

  // stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_crc))
    else $error("output word changed while stalled");

  // nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind crc16_block_framer_unit cbf_checker u_cbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .is_crc    (is_crc),
  .packet_end(packet_end)
);

/* test/tb_crc16_block_framer_unit.sv */
module tb_crc16_block_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  // group size the block is built with
  localparam int unsigned GROUP_BYTES = DATA_BYTES_DEF;

  // cycles to keep watching the output once nothing is expected
  localparam int unsigned DRAIN_CYCLES = 20;

  // random part split into four idling phases
  localparam int unsigned NUM_PHASES = 4;

  // one output word as the block should present it
  typedef struct packed {
    logic [7:0] value;
    logic       crc_flag;
    logic       end_flag;
  } frame_word_t;

  // predicts the framed byte stream and checks it word by word
  class frame_tracker;
    int unsigned   group_size;
    logic [15:0]   running_crc;
    int unsigned   group_fill;
    frame_word_t   pending_words[$];
    int unsigned   mismatches;

    function new(input int unsigned size);
      group_size  = size;
      running_crc = CRC_INIT;
      group_fill  = 0;
      mismatches  = 0;
    endfunction

    // bitwise crc-16, data bit folded into the feedback, msb first
    function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ d[i];
        r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
    endfunction

    // an accepted data byte: echo, and crc pair at the end of a group
    function void note_byte(input logic [7:0] b);
      pending_words.push_back('{value: b, crc_flag: 1'b0, end_flag: 1'b0});
      running_crc = crc_after(running_crc, b);
      group_fill++;
      if (group_fill >= group_size) begin
        pending_words.push_back('{value: running_crc[15:8], crc_flag: 1'b1, end_flag: 1'b0});
        pending_words.push_back('{value: running_crc[7:0], crc_flag: 1'b1, end_flag: 1'b1});
        running_crc = CRC_INIT;
        group_fill  = 0;
      end
    endfunction

    function int unsigned pending_count();
      return pending_words.size();
    endfunction

    // compare a taken output word with the oldest prediction
    function void check_word(input logic [7:0] ob, input logic ic, input logic pe);
      frame_word_t w;
      if (pending_words.size() == 0) begin
        $error("out_byte: no word expected, got %02h (is_crc %0b, packet_end %0b)",
               ob, ic, pe);
        mismatches++;
        return;
      end
      w = pending_words.pop_front();
      if (ob !== w.value) begin
        $error("out_byte: expected %02h, got %02h", w.value, ob);
        mismatches++;
      end
      if (ic !== w.crc_flag) begin
        $error("is_crc: expected %0b, got %0b", w.crc_flag, ic);
        mismatches++;
      end
      if (pe !== w.end_flag) begin
        $error("packet_end: expected %0b, got %0b", w.end_flag, pe);
        mismatches++;
      end
    endfunction
  endclass

  // block ports, all inputs known from time zero
  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte  = 8'h00;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       packet_end;

  // idling odds in percent, changed per phase
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;

  // output word seen at the falling edge, taken at the next rising edge
  logic       out_take = 1'b0;
  logic [7:0] seen_byte;
  logic       seen_crc;
  logic       seen_end;

  frame_tracker tracker = new(GROUP_BYTES);

  crc16_block_framer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_crc     (is_crc),
    .packet_end (packet_end)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // all block signals settle between edges, so the falling edge sees
  // exactly what the next rising edge will act on
  always @(negedge clk) begin
    out_take  = !rst && out_valid && out_ready;
    seen_byte = out_byte;
    seen_crc  = is_crc;
    seen_end  = packet_end;
  end

  // receiver: check the word taken at this edge, then pick the next ready
  always @(posedge clk) begin
    if (out_take) begin
      tracker.check_word(seen_byte, seen_crc, seen_end);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // present one data word and hold it until the block takes it
  // called right after a rising edge
  task automatic send_byte(input logic [7:0] b);
    // random idle gap, valid low for each idle cycle
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    // look for ready at the falling edge, the word goes at the next rising one
    @(negedge clk);
    while (!in_ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    tracker.note_byte(b);
  endtask

  // hold the input back until every predicted word has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) begin
      @(posedge clk);
    end
  endtask

  // random data: mostly uniform, now and then an all-zero or all-one byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // main sequence
  initial begin
    logic [7:0]  directed_bytes[24];
    int unsigned phase_items[NUM_PHASES];
    int unsigned phase_idle[NUM_PHASES];
    int unsigned phase_stall[NUM_PHASES];

    // extremes, single bits, alternating patterns, then a few plain values
    directed_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                       8'h0F, 8'hF0, 8'h02, 8'h40, 8'h04, 8'h20, 8'h08, 8'h10,
                       8'hFF, 8'hFF, 8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'hC3};

    // no idling, sender idle, receiver stalling, both
    phase_items = '{86, 86, 87, 87};
    phase_idle  = '{0, 57, 0, 27};
    phase_stall = '{0, 0, 57, 27};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, back to back, stopping short of a full group
    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end

    // pause mid-group: the block must keep its running crc and count
    hold_until_drained();

    // random part, group boundaries fall wherever the count takes them
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = phase_idle[p];
      sink_stall_pct  = phase_stall[p];
      for (int unsigned n = 0; n < phase_items[p]; n++) begin
        send_byte(pick_byte());
      end
      // one more full drain halfway through
      if (p == 1) begin
        hold_until_drained();
      end
    end

    // let everything out with the receiver still stalling at random
    in_valid <= 1'b0;
    while (tracker.pending_count() != 0) begin
      @(posedge clk);
    end
    // keep checking for stray words
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("tb_crc16_block_framer_unit: PASS");
    end else begin
      $display("tb_crc16_block_framer_unit: FAIL");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #5ms;
    $display("tb_crc16_block_framer_unit: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_crc_core.sv
hw/rtl/cbf_emit.sv
hw/rtl/crc16_block_framer_unit.sv
hw/rtl/cbf_checker.sv
test/tb_crc16_block_framer_unit.sv
